>>> hw/rtl/olad_pkg.sv
// Package for the ordered list block: sizes, mode and status codes, and word types.
// Used by olad_front, olad_back and ordered_list_append_delete.
// It has no dependencies.
package olad_pkg;

    // List size and the widths that follow from it.
    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] mode_t;
    typedef logic [1:0] status_t;

    // Request modes.
    localparam mode_t MODE_APPEND = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;
    localparam mode_t MODE_READ   = 2'd2;
    localparam mode_t MODE_UNUSED = 2'd3;

    // Result status codes.
    localparam status_t STAT_DONE     = 2'd0;
    localparam status_t STAT_FULL     = 2'd1;
    localparam status_t STAT_NO_MATCH = 2'd2;
    localparam status_t STAT_EMPTY    = 2'd3;

    // Input word.
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic signed [31:0] item;
        status_t            status;
        logic               last;
    } out_word_t;

    // Command held in the queue.
    typedef struct packed {
        mode_t              op;
        logic signed [31:0] value;
    } cmd_t;

    // Head of the command queue as seen by the back.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

>>> hw/rtl/olad_front.sv
// Front of the ordered list block: accepts input words, drops the unused mode,
// and keeps a short command queue for the back. Depends on olad_pkg.
module olad_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  olad_pkg::in_word_t s_word,
    output olad_pkg::cmd_head_t head,
    input  logic               pop
);
    import olad_pkg::*;

    cmd_t              q_data_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              push;
    logic              do_pop;

    // Accept while the queue has room; words with the unused mode are taken and dropped.
    assign s_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;
    assign push    = accept && (s_word.mode != MODE_UNUSED);
    assign do_pop  = pop && (count_reg != '0);

    // Queue head toward the back.
    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_data_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_data_reg[wr_ptr_reg] <= '{op: s_word.mode, value: s_word.value};
        end
    end

endmodule

>>> hw/rtl/olad_back.sv
// Back of the ordered list block: holds the list in a row of registers and carries out
// append, delete and readout commands into an output register. Depends on olad_pkg.
module olad_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  olad_pkg::cmd_head_t head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output olad_pkg::out_word_t m_word
);
    import olad_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DEL  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic signed [31:0] entries_reg  [DEPTH];
    logic signed [31:0] entries_next [DEPTH];
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [DEPTH-1:0]   match_reg, match_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_word_reg, m_word_next;
    logic               out_free;
    logic               emit;
    out_word_t          emit_word;
    logic [DEPTH-1:0]   shift_mask;
    logic               found;

    assign out_free = !m_valid_reg || m_ready;

    // Entries at or after the first match take their upper neighbor.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            shift_mask[i] = |(match_reg << (DEPTH - 1 - i));
        end
        found = |match_reg;
    end

    // Command sequencer.
    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        rd_idx_next  = rd_idx_reg;
        match_next   = match_reg;
        entries_next = entries_reg;
        pop          = 1'b0;
        emit         = 1'b0;
        emit_word    = '{item: '0, status: STAT_DONE, last: 1'b1};

        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid && out_free) begin
                    pop = 1'b1;
                    unique case (head.cmd.op)
                        MODE_APPEND: begin
                            emit = 1'b1;
                            if (occ_reg == OCC_W'(DEPTH)) begin
                                emit_word.status = STAT_FULL;
                            end else begin
                                entries_next[occ_reg[IDX_W-1:0]] = head.cmd.value;
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                        MODE_DELETE: begin
                            // Compare every valid entry now; the shift follows in ST_DEL once the output is free.
                            for (int i = 0; i < DEPTH; i++) begin
                                match_next[i] = (OCC_W'(i) < occ_reg) &&
                                                (entries_reg[i] == head.cmd.value);
                            end
                            state_next = ST_DEL;
                        end
                        MODE_READ: begin
                            emit = 1'b1;
                            if (occ_reg == '0) begin
                                emit_word.status = STAT_EMPTY;
                            end else begin
                                emit_word.item = entries_reg[0];
                                emit_word.last = (occ_reg == OCC_W'(1));
                                if (occ_reg != OCC_W'(1)) begin
                                    rd_idx_next = IDX_W'(1);
                                    state_next  = ST_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DEL: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (found) begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            if (shift_mask[i]) begin
                                entries_next[i] = entries_reg[i+1];
                            end
                        end
                        occ_next = occ_reg - OCC_W'(1);
                    end else begin
                        emit_word.status = STAT_NO_MATCH;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    emit           = 1'b1;
                    emit_word.item = entries_reg[rd_idx_reg];
                    emit_word.last = (OCC_W'(rd_idx_reg) == occ_reg - OCC_W'(1));
                    if (emit_word.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded when a word is produced, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_word_next  = emit_word;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
        rd_idx_reg  <= rd_idx_next;
        match_reg   <= match_next;
        m_word_reg  <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

>>> hw/rtl/ordered_list_append_delete.sv
// Top level of the ordered list block: front with command queue, and the back.
// Depends on olad_pkg, olad_front and olad_back.
//
//   Channel  Direction  Word type   Handshake
//   s_       in         in_word_t   s_valid / s_ready
//   m_       out        out_word_t  m_valid / m_ready
//
// An append is done in ST_IDLE; a delete compares all entries in ST_IDLE,
// then shifts in ST_DEL; a readout of N entries gives N words, one per cycle
// while the output is not stalled. Commands reach the back via the queue.
// Reset clears the queue, the occupancy count, the sequencer and the output
// valid; list entries are not cleared and are read only below the count.
// A stalled output holds the back; the front keeps taking words until its
// two-entry queue is full.
module ordered_list_append_delete (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olad_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output olad_pkg::out_word_t m_word
);
    import olad_pkg::*;

    cmd_head_t head;
    logic      pop;

    olad_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .head    (head),
        .pop     (pop)
    );

    olad_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // The back only takes a command that is present.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head.valid)
        else $error("command popped from an empty queue");

    // An empty-list word is always the last of its request and carries no item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.status == STAT_EMPTY) |-> (m_word.last && m_word.item == '0))
        else $error("empty-list word malformed");

    // Every status other than done ends its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.status != STAT_DONE) |-> m_word.last)
        else $error("error status without last");

    // A nonzero item only comes with a done status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.item != '0) |-> (m_word.status == STAT_DONE))
        else $error("item on a non-readout word");

endmodule

>>> test/ordered_list_append_delete_tb.sv
// Testbench for ordered_list_append_delete: directed and random appends, deletes and readouts.
// A scoreboard class predicts every result word from its own copy of the list.
// Depends on olad_pkg and the ordered_list_append_delete RTL.
module ordered_list_append_delete_tb;
    import olad_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 127;
    localparam int TAIL_CYCLES     = 16;
    localparam int MAX_REPORTS     = 10;

    // Predicts the result words of the list block and checks what comes out.
    class olad_scoreboard;
        logic signed [31:0] list_q[$];
        out_word_t          expected_q[$];
        int                 errors;
        int                 words_checked;
        int                 requests;
        int                 full_drops;
        int                 unmatched;
        int                 empty_reads;

        function new();
            errors        = 0;
            words_checked = 0;
            requests      = 0;
            full_drops    = 0;
            unmatched     = 0;
            empty_reads   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_expect(logic signed [31:0] item, status_t status, logic last);
            out_word_t r;
            r.item   = item;
            r.status = status;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // Applies one accepted input word to the list copy and queues its results.
        function void note_input(in_word_t w);
            int idx;
            idx = -1;
            case (w.mode)
                MODE_APPEND: begin
                    requests++;
                    if (list_q.size() >= DEPTH) begin
                        full_drops++;
                        push_expect('0, STAT_FULL, 1'b1);
                    end else begin
                        list_q.push_back(w.value);
                        push_expect('0, STAT_DONE, 1'b1);
                    end
                end
                MODE_DELETE: begin
                    requests++;
                    // Only the first match from the head is removed.
                    for (int i = 0; i < list_q.size(); i++) begin
                        if (idx < 0 && list_q[i] == w.value) idx = i;
                    end
                    if (idx < 0) begin
                        unmatched++;
                        push_expect('0, STAT_NO_MATCH, 1'b1);
                    end else begin
                        list_q.delete(idx);
                        push_expect('0, STAT_DONE, 1'b1);
                    end
                end
                MODE_READ: begin
                    requests++;
                    if (list_q.size() == 0) begin
                        empty_reads++;
                        push_expect('0, STAT_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < list_q.size(); i++)
                            push_expect(list_q[i], STAT_DONE, i == list_q.size() - 1);
                    end
                end
                default: begin
                    // The unused mode is dropped without a result.
                end
            endcase
        endfunction

        // Compares one accepted result word with the oldest expectation.
        function void check_result(out_word_t got);
            out_word_t want;
            words_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("word %0d unexpected: item %0d status %0d last %0b",
                             words_checked, got.item, got.status, got.last);
            end else begin
                want = expected_q.pop_front();
                if (got.item !== want.item || got.status !== want.status ||
                    got.last !== want.last) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("word %0d: expected item %0d status %0d last %0b",
                                 words_checked, want.item, want.status, want.last);
                        $display("word %0d:      got item %0d status %0d last %0b",
                                 words_checked, got.item, got.status, got.last);
                    end
                end
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    int s_idle_pct    = 29;
    int m_idle_pct    = 57;
    int in_count      = 0;
    int stall_cycles  = 0;
    int counted_items = 0;

    olad_scoreboard sb = new();

    ordered_list_append_delete u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Sample both handshakes at the rising edge; the watchdog runs here too.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_word);
                in_count++;
            end
            if (m_valid && m_ready)
                sb.check_result(m_word);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no word moved for %0d cycles, %0d results outstanding",
                         stall_cycles, sb.pending());
                $display("ordered_list_append_delete_tb: FAIL");
                $finish;
            end
        end
    end

    // The receiver stalls at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    // Small values for 40 percent of draws so that duplicates and matches are common.
    function automatic logic signed [31:0] any_value();
        logic signed [31:0] v;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = $urandom_range(0, 7);
            v = v - 4;
        end else if (r < 55) begin
            case ($urandom_range(0, 3))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = '0;
                default: v = '1;
            endcase
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    // A value held somewhere in the list, or any value if it is empty.
    function automatic logic signed [31:0] held_value();
        if (sb.list_q.size() == 0)
            return any_value();
        return sb.list_q[$urandom_range(0, sb.list_q.size() - 1)];
    endfunction

    // Offers one input word after a random gap and waits for it to be taken.
    task automatic send_item(mode_t mode, logic signed [31:0] value);
        in_word_t w;
        int       n;
        w.mode  = mode;
        w.value = value;
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        n = in_count;
        s_word  <= w;
        s_valid <= 1'b1;
        do @(negedge aclk); while (in_count == n);
        if (mode != MODE_UNUSED)
            counted_items++;
    endtask

    // Holds the sender off until every expected result word has come.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // Random requests, with bursts that fill the list or empty it.
    task automatic run_phase(int s_pct, int m_pct, int quota);
        int target;
        int r;
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        target     = counted_items + quota;
        while (counted_items < target) begin
            if ($urandom_range(0, 99) < 3)
                wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 4) begin
                while (sb.list_q.size() < DEPTH)
                    send_item(MODE_APPEND, any_value());
                repeat ($urandom_range(1, 3)) send_item(MODE_APPEND, any_value());
                send_item(MODE_READ, $urandom());
            end else if (r < 8) begin
                while (sb.list_q.size() > 0)
                    send_item(MODE_DELETE, held_value());
                send_item(MODE_DELETE, any_value());
                send_item(MODE_READ, $urandom());
            end else if (r < 48) begin
                send_item(MODE_APPEND, any_value());
            end else if (r < 72) begin
                send_item(MODE_DELETE, held_value());
            end else if (r < 78) begin
                send_item(MODE_DELETE, any_value());
            end else if (r < 94) begin
                send_item(MODE_READ, $urandom());
            end else begin
                send_item(MODE_UNUSED, $urandom());
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list, extremes, duplicates, and deletes at head, middle and tail.
        send_item(MODE_READ, '0);
        send_item(MODE_DELETE, 32'sd5);
        send_item(MODE_UNUSED, '1);
        send_item(MODE_APPEND, 32'sh8000_0000);
        send_item(MODE_APPEND, 32'sh7FFF_FFFF);
        send_item(MODE_APPEND, '0);
        send_item(MODE_APPEND, '1);
        send_item(MODE_APPEND, 32'sd7);
        send_item(MODE_APPEND, '0);
        send_item(MODE_READ, '1);
        send_item(MODE_DELETE, '0);
        send_item(MODE_DELETE, 32'sd123);
        send_item(MODE_DELETE, 32'sh8000_0000);
        send_item(MODE_DELETE, '0);
        send_item(MODE_READ, '0);
        send_item(MODE_DELETE, '1);
        send_item(MODE_DELETE, 32'sh7FFF_FFFF);
        send_item(MODE_DELETE, 32'sd7);
        send_item(MODE_READ, '0);
        send_item(MODE_UNUSED, '0);
        wait_for_results();

        run_phase(29, 57, ITEMS_PER_PHASE);
        run_phase(57, 29, ITEMS_PER_PHASE);
        run_phase(0, 0, ITEMS_PER_PHASE);

        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Ran %0d append, delete and readout requests and checked %0d result words,",
                 sb.requests, sb.words_checked);
        $display("with %0d full drops, %0d unmatched deletes, %0d empty readouts, %0d mismatches.",
                 sb.full_drops, sb.unmatched, sb.empty_reads, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ordered_list_append_delete_tb: PASS");
        else
            $display("ordered_list_append_delete_tb: FAIL");
        $finish;
    end

endmodule

>>> ordered_list_append_delete.f
hw/rtl/olad_pkg.sv
hw/rtl/olad_front.sv
hw/rtl/olad_back.sv
hw/rtl/ordered_list_append_delete.sv
test/ordered_list_append_delete_tb.sv
